[design/dqsr_pkg.sv]
// Package for the double-ended queue with search and remove.
// Holds the request and response types, operation and status codes.
// No dependencies.
package dqsr_pkg;

    // default number of slots in the circular store
    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } dqsr_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [COUNT_W-1:0]       count;
    } dqsr_rsp_t;

endpackage

[design/dqsr_ram.sv]
// Entry store: one write port, one read port, registered read data.
// Depends on dqsr_pkg for the default depth and data width.
module dqsr_ram #(
    parameter int DEPTH = dqsr_pkg::DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [dqsr_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [dqsr_pkg::DATA_W-1:0] rd_data
);
    import dqsr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/deque_with_search_and_remove.sv]
// Bounded double-ended queue of signed 32-bit values over a circular store of DEPTH slots held
// in one synchronous RAM (one write and one read port, registered read data). One request is
// worked at a time and gives one response. Pushes, pops, the error cases and ignored op codes
// go from acceptance to a valid response through reads of the front and back slots through
// the RAM port, then the load of the response register. Contains adds a scan through the RAM,
// one entry per cycle with the compare in the cycle after the read, ending at the first match or
// at the back entry. Remove adds, after the match, a shift of the later entries one slot
// toward the front, one entry per cycle, and none when the match is the back entry. The response
// waits in an output register; the next request is taken once the current response has been
// loaded there. Depends on dqsr_pkg and dqsr_ram.
module deque_with_search_and_remove #(
    parameter int DEPTH = dqsr_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dqsr_pkg::dqsr_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output dqsr_pkg::dqsr_rsp_t m_rsp
);
    import dqsr_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_RFRONT = 3'd3;
    localparam logic [2:0] ST_RBACK  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IDXW-1:0]     head_reg, head_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;
    logic [CNTW-1:0]     ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [CNTW-1:0]     pend_pos_reg, pend_pos_next;
    logic [DATA_W-1:0]   front_reg, front_next;
    logic                m_valid_reg, m_valid_next;
    dqsr_rsp_t           m_rsp_reg, m_rsp_next;

    logic                wr_en;
    logic [IDXW-1:0]     wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [IDXW-1:0]     rd_addr;
    logic [DATA_W-1:0]   rd_data;
    logic                m_load;
    logic                is_full;
    logic                is_empty;
    logic [IDXW-1:0]     head_dec;
    logic [IDXW-1:0]     head_inc;

    // slot of a queue position: (head + pos) mod DEPTH, sum stays below twice DEPTH for pos up to DEPTH
    function automatic logic [IDXW-1:0] slot_of(input logic [IDXW-1:0] head,
                                                input logic [CNTW-1:0] pos);
        logic [CNTW:0] sum;
        sum = (CNTW+1)'(head) + (CNTW+1)'(pos);
        if (sum >= (CNTW+1)'(DEPTH)) begin
            sum = sum - (CNTW+1)'(DEPTH);
        end
        return sum[IDXW-1:0];
    endfunction

    dqsr_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign is_full  = (cnt_reg == CNTW'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign head_dec = (head_reg == '0) ? IDXW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDXW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // sequencer: update, scan, shift, read front and back, then load the response
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        pend_pos_next = pend_pos_reg;
        front_next    = front_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = s_req.value;
        rd_en         = 1'b0;
        rd_addr       = '0;
        m_load        = 1'b0;
        s_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_req.op;
                    value_next  = s_req.value;
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_RFRONT;
                    case (s_req.op)
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                head_next = head_dec;
                                wr_en     = 1'b1;
                                wr_addr   = head_dec;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = slot_of(head_reg, cnt_reg);
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                head_next = head_inc;
                                cnt_next  = cnt_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        OP_CONTAINS, OP_REMOVE: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one read per cycle, compare the returned entry in the cycle after its read
            ST_SCAN: begin
                if (pend_reg && (rd_data == value_reg)) begin
                    found_next = 1'b1;
                    pend_next  = 1'b0;
                    if (op_reg == OP_REMOVE) begin
                        ptr_next   = pend_pos_reg + 1'b1;
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_RFRONT;
                    end
                end else if (ptr_reg < cnt_reg) begin
                    rd_en         = 1'b1;
                    rd_addr       = slot_of(head_reg, ptr_reg);
                    pend_next     = 1'b1;
                    pend_pos_next = ptr_reg;
                    ptr_next      = ptr_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_RFRONT;
                    end
                end
            end

            // read entry at ptr, write the returned one a place toward the front
            ST_SHIFT: begin
                wr_data = rd_data;
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = slot_of(head_reg, pend_pos_reg - 1'b1);
                end
                if (ptr_reg < cnt_reg) begin
                    rd_en         = 1'b1;
                    rd_addr       = slot_of(head_reg, ptr_reg);
                    pend_next     = 1'b1;
                    pend_pos_next = ptr_reg;
                    ptr_next      = ptr_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_RFRONT;
                    end
                end
            end

            ST_RFRONT: begin
                rd_en      = !is_empty;
                rd_addr    = slot_of(head_reg, '0);
                state_next = ST_RBACK;
            end

            ST_RBACK: begin
                front_next = rd_data;
                rd_en      = !is_empty;
                rd_addr    = slot_of(head_reg, cnt_reg - 1'b1);
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response register
    always_comb begin
        m_rsp_next   = m_rsp_reg;
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next           = 1'b1;
            m_rsp_next.status      = status_reg;
            m_rsp_next.found       = found_reg;
            m_rsp_next.front_value = is_empty ? '0 : front_reg;
            m_rsp_next.back_value  = is_empty ? '0 : rd_data;
            m_rsp_next.count       = COUNT_W'(cnt_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        ptr_reg      <= ptr_next;
        pend_pos_reg <= pend_pos_next;
        front_reg    <= front_next;
        m_rsp_reg    <= m_rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

`ifndef SYNTH
    // count never passes the store depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(DEPTH))
        else $error("entry count above depth");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in work");

    // loaded response carries the count held after the operation
    a_rsp_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |=> (m_rsp.count == COUNT_W'(cnt_reg)))
        else $error("response count differs from held count");
`endif

endmodule
